### hdl/wma_pkg.sv
// shared constants, types and helpers for the windowed moving average unit
package wma_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
	localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
	localparam int WSIZE_BITS  = 7;
	localparam int STEP_BITS   = $clog2(SUM_BITS);

	localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(16);

	localparam logic [SUM_BITS-1:0] SAT_MAG = SUM_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] AVG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic capture;
		logic read;
		logic update;
		logic clear;
		logic div_start;
		logic out_load;
	} wma_cmd_t;

	typedef struct packed {
		logic func_clear;
		logic div_done;
		logic out_free;
	} wma_sts_t;

	// window size as used: zero acts as one, oversize clamps to the store depth
	function automatic logic [COUNT_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] ws);
		logic [COUNT_BITS-1:0] w;
		if (ws == '0)
			w = COUNT_BITS'(1);
		else if (32'(ws) > MAX_WINDOW)
			w = COUNT_BITS'(MAX_WINDOW);
		else
			w = COUNT_BITS'(ws);
		return w;
	endfunction

endpackage

### hdl/wma_div.sv
// restoring radix-2 divider, unsigned sum magnitude by sample count, one bit per cycle
module wma_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wma_pkg::SUM_BITS-1:0]   dividend,
	input  logic [wma_pkg::COUNT_BITS-1:0] divisor,
	output logic [wma_pkg::SUM_BITS-1:0]   quotient,
	output logic                         done
);
	import wma_pkg::*;

	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SUM_BITS - 1);

	logic [COUNT_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0]   quo_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;
	logic [COUNT_BITS-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, quo_q[SUM_BITS-1]};
		diff     = shifted - {1'b0, divisor};
		fits     = shifted >= {1'b0, divisor};
		rem_next = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && step_q == STEP_LAST) |=> (done_q && !busy_q))
		else $error("divider did not finish after last step");

endmodule

### hdl/wma_dpath.sv
// datapath: window size register, sample ring store, running sum, divider and result register
module wma_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wma_pkg::wma_cmd_t             cmd,
	output wma_pkg::wma_sts_t             sts,
	input  logic                          window_size_we,
	input  logic [wma_pkg::WSIZE_BITS-1:0]  window_size_wdata,
	input  logic                          func,
	input  logic signed [wma_pkg::SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [wma_pkg::SAMPLE_BITS-1:0] average,
	output logic [wma_pkg::COUNT_BITS-1:0]  sample_count
);
	import wma_pkg::*;

	logic [WSIZE_BITS-1:0]        window_size_q;
	logic [SLOT_BITS-1:0]         write_slot_q;
	logic [COUNT_BITS-1:0]        held_q;
	logic signed [SUM_BITS-1:0]   window_sum_q;
	logic                         func_q;
	logic [SAMPLE_BITS-1:0]       sample_q;
	logic [SLOT_BITS-1:0]         slot_q;
	logic [SAMPLE_BITS-1:0]       rd_data_q;
	logic [SAMPLE_BITS-1:0]       store [MAX_WINDOW];

	logic                         out_valid_q;
	logic [SAMPLE_BITS-1:0]       average_q;
	logic [COUNT_BITS-1:0]        sample_count_q;

	logic [COUNT_BITS-1:0]        win_w;
	logic [SLOT_BITS-1:0]         slot_c;
	logic [COUNT_BITS-1:0]        next_slot;
	logic                         full;
	logic signed [SUM_BITS-1:0]   samp_ext;
	logic signed [SUM_BITS-1:0]   old_ext;
	logic signed [SUM_BITS-1:0]   sum_next;
	logic [SUM_BITS-1:0]          sum_mag;
	logic [SUM_BITS-1:0]          quotient;
	logic                         div_done;
	logic [SAMPLE_BITS-1:0]       avg_c;

	always_comb begin
		win_w     = eff_window(window_size_q);
		// a slot left beyond a shrunk window wraps to the start
		slot_c    = ({1'b0, write_slot_q} >= win_w) ? '0 : write_slot_q;
		next_slot = COUNT_BITS'(slot_q) + 1'b1;
		full      = held_q >= win_w;
		samp_ext  = {{SLOT_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
		old_ext   = full ? {{SLOT_BITS{rd_data_q[SAMPLE_BITS-1]}}, rd_data_q} : '0;
		sum_next  = window_sum_q + samp_ext - old_ext;
		sum_mag   = window_sum_q[SUM_BITS-1] ? (~window_sum_q + 1'b1) : window_sum_q;
	end

	always_comb begin
		if (func_q == FUNC_CLEAR)
			avg_c = '0;
		else if (window_sum_q[SUM_BITS-1])
			avg_c = (quotient > SAT_MAG) ? AVG_MIN : (~quotient[SAMPLE_BITS-1:0] + 1'b1);
		else
			avg_c = (quotient >= SAT_MAG) ? AVG_MAX : quotient[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WSIZE_RESET;
			write_slot_q  <= '0;
			held_q        <= '0;
			window_sum_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (window_size_we)
				window_size_q <= window_size_wdata;
			if (cmd.clear) begin
				write_slot_q <= '0;
				held_q       <= '0;
				window_sum_q <= '0;
			end else if (cmd.update) begin
				window_sum_q <= sum_next;
				write_slot_q <= (next_slot >= win_w) ? '0 : next_slot[SLOT_BITS-1:0];
				if (!full)
					held_q <= held_q + 1'b1;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q   <= func;
			sample_q <= sample;
		end
		if (cmd.read) begin
			slot_q    <= slot_c;
			rd_data_q <= store[slot_c];
		end
		if (cmd.update)
			store[slot_q] <= sample_q;
		if (cmd.out_load) begin
			average_q      <= avg_c;
			sample_count_q <= held_q;
		end
	end

	wma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (held_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		sts.func_clear = func_q == FUNC_CLEAR;
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign average      = average_q;
	assign sample_count = sample_count_q;

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !cmd.clear) |=> held_q != '0)
		else $error("sample count zero after an add");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result word overwritten before it was taken");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.out_load))
		else $error("result valid without a load");

endmodule

### hdl/wma_ctrl.sv
// controller state machine sequencing read, update, divide or clear, and result hand-off
module wma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wma_pkg::wma_sts_t sts,
	output wma_pkg::wma_cmd_t cmd
);
	import wma_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_READ   = 7'b0000010,
		S_UPDATE = 7'b0000100,
		S_START  = 7'b0001000,
		S_DIVIDE = 7'b0010000,
		S_CLEAR  = 7'b0100000,
		S_DONE   = 7'b1000000
	} wma_state_t;

	wma_state_t state_q;
	wma_state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid)
					state_d = S_READ;
			end
			S_READ: begin
				// clear skips the store and the divider
				if (sts.func_clear) begin
					state_d = S_CLEAR;
				end else begin
					cmd.read = 1'b1;
					state_d  = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_START;
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (sts.div_done)
					state_d = S_DONE;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### hdl/windowed_moving_average_unit.sv
// top level of the windowed moving average unit
// Each word on the input channel either adds a signed Q16.16 sample to a ring of the
// last window_size samples (1 to 64; 0 acts as 1, larger values as 64) or clears the
// window, and produces one result word: the running sum divided by the number of held
// samples, truncated toward zero and saturated to 32 bits, with that count. An add word
// passes through store read, sum update, the 38-step one-bit-per-cycle divider and
// hand-off; a clear word skips the store and the divider. One word is in work at a time;
// the result register lets the next word be accepted while the previous result waits.
// Write window_size only while idle and clear the window after changing it.
module windowed_moving_average_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  window_size_we,
	input  logic [wma_pkg::WSIZE_BITS-1:0]         window_size_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic signed [wma_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [wma_pkg::SAMPLE_BITS-1:0] average,
	output logic [wma_pkg::COUNT_BITS-1:0]         sample_count
);
	import wma_pkg::*;

	wma_cmd_t cmd;
	wma_sts_t sts;

	wma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wma_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.window_size_we    (window_size_we),
		.window_size_wdata (window_size_wdata),
		.func              (func),
		.sample            (sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.average           (average),
		.sample_count      (sample_count)
	);

endmodule

### bench/windowed_moving_average_unit_tb.sv
// self-checking testbench for the windowed moving average unit
module windowed_moving_average_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wma_pkg::*;

	localparam int unsigned WORD_TARGET = 1650;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 48;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] average;
		logic [COUNT_BITS-1:0]         sample_count;
	} avg_word_t;

	// running model of the averaging window plus the averages still owed by the block
	class window_average_board;
		logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
		bit                            ring_written [MAX_WINDOW];
		int unsigned                   next_slot;
		logic [COUNT_BITS-1:0]         held;
		logic signed [SUM_BITS-1:0]    running_sum;
		logic [WSIZE_BITS-1:0]         window_reg;
		avg_word_t                     owed_averages [$];
		int unsigned                   failures;
		int unsigned                   checked;

		function new();
			next_slot = 0;
			held = '0;
			running_sum = '0;
			window_reg = WSIZE_RESET;
			failures = 0;
			checked = 0;
			foreach (ring_written[i])
				ring_written[i] = 1'b0;
		endfunction

		function void set_window(logic [WSIZE_BITS-1:0] ws);
			window_reg = ws;
		endfunction

		function bit ring_full();
			foreach (ring_written[i])
				if (!ring_written[i])
					return 1'b0;
			return 1'b1;
		endfunction

		function int unsigned pending();
			return owed_averages.size();
		endfunction

		// accepted input word: advance the window and queue the average it must produce
		function void take_input(logic f, logic signed [SAMPLE_BITS-1:0] s);
			avg_word_t   exp_word;
			int unsigned w;
			int unsigned slot;
			longint      quo;
			longint      hi;
			longint      lo;
			hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
			lo = -hi - 1;
			if (f == FUNC_CLEAR) begin
				held = '0;
				next_slot = 0;
				running_sum = '0;
				exp_word.average = '0;
				exp_word.sample_count = '0;
			end else begin
				if (window_reg == '0)
					w = 1;
				else if (window_reg > MAX_WINDOW)
					w = MAX_WINDOW;
				else
					w = window_reg;
				slot = (next_slot >= w) ? 0 : next_slot;
				if (held < w)
					held = held + 1'b1;
				else
					running_sum = running_sum - ring[slot];
				ring[slot] = s;
				ring_written[slot] = 1'b1;
				running_sum = running_sum + s;
				next_slot = (slot + 1 >= w) ? 0 : slot + 1;
				quo = longint'(running_sum) / longint'(held);
				if (quo > hi)
					quo = hi;
				if (quo < lo)
					quo = lo;
				exp_word.average = SAMPLE_BITS'(quo);
				exp_word.sample_count = held;
			end
			owed_averages.push_back(exp_word);
		endfunction

		function void match_result(logic signed [SAMPLE_BITS-1:0] avg, logic [COUNT_BITS-1:0] cnt);
			avg_word_t exp_word;
			checked++;
			if (owed_averages.size() == 0) begin
				$error("result word with nothing expected: average %0d sample_count %0d", avg, cnt);
				failures++;
				return;
			end
			exp_word = owed_averages.pop_front();
			if (avg !== exp_word.average) begin
				$error("average mismatch: expected %0d, actual %0d", exp_word.average, avg);
				failures++;
			end
			if (cnt !== exp_word.sample_count) begin
				$error("sample_count mismatch: expected %0d, actual %0d",
					exp_word.sample_count, cnt);
				failures++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          window_size_we = 1'b0;
	logic [WSIZE_BITS-1:0]         window_size_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          func = FUNC_ADD;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] average;
	logic [COUNT_BITS-1:0]         sample_count;

	window_average_board board = new();

	int unsigned send_gap_pct = 9;
	int unsigned take_gap_pct = 73;
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned n_words = 0;
	int unsigned n_clears = 0;
	int unsigned n_settings = 0;
	int unsigned n_kept = 0;

	windowed_moving_average_unit dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_size_we    (window_size_we),
		.window_size_wdata (window_size_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.func              (func),
		.sample            (sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.average           (average),
		.sample_count      (sample_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check accepted words, then pick ready for the next edge
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.match_result(average, sample_count);
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
		end
	end

	task automatic push_word(input logic f, input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		board.take_input(f, s);
		n_words++;
		if (f == FUNC_CLEAR)
			n_clears++;
	endtask

	// wait until every owed average is back and the divider has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(input logic [WSIZE_BITS-1:0] ws);
		window_size_we <= 1'b1;
		window_size_wdata <= ws;
		@(posedge clk);
		window_size_we <= 1'b0;
		board.set_window(ws);
		n_settings++;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return AVG_MAX;
			1: return AVG_MIN;
			2, 3, 4: return $urandom();
			5: return SAMPLE_BITS'(int'($urandom_range(0, 8)) - 4);
			default: return SAMPLE_BITS'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	initial begin
		logic [WSIZE_BITS-1:0] ws;
		int unsigned           eff;
		int unsigned           run_len;
		bit                    first_phase;
		bit                    hold_done;
		first_phase = 1'b1;
		hold_done = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of 16 with the sample extremes and a clear carrying junk
		push_word(FUNC_ADD, AVG_MAX);
		push_word(FUNC_ADD, AVG_MAX);
		push_word(FUNC_ADD, AVG_MIN);
		push_word(FUNC_ADD, '1);
		push_word(FUNC_ADD, SAMPLE_BITS'(1));
		push_word(FUNC_ADD, '0);
		push_word(FUNC_CLEAR, 32'hdead_beef);

		// zero acts as a window of one
		settle();
		set_window('0);
		push_word(FUNC_CLEAR, '1);
		push_word(FUNC_ADD, 32'h1234_5678);
		push_word(FUNC_ADD, AVG_MIN);
		push_word(FUNC_ADD, AVG_MAX);

		// oversize clamps to the full store
		settle();
		set_window('1);
		push_word(FUNC_CLEAR, '0);
		push_word(FUNC_ADD, AVG_MAX);
		push_word(FUNC_ADD, AVG_MIN);
		push_word(FUNC_ADD, 32'hffff_0000);

		// window of two wraps right away
		settle();
		set_window(WSIZE_BITS'(2));
		push_word(FUNC_CLEAR, '0);
		push_word(FUNC_ADD, SAMPLE_BITS'(3));
		push_word(FUNC_ADD, -SAMPLE_BITS'(4));
		push_word(FUNC_ADD, SAMPLE_BITS'(5));
		push_word(FUNC_ADD, SAMPLE_BITS'(7));

		while (n_words < WORD_TARGET) begin
			settle();
			if (n_words < WORD_TARGET / 3) begin
				send_gap_pct = 9;
				take_gap_pct = 73;
			end else if (n_words < 2 * WORD_TARGET / 3) begin
				send_gap_pct = 73;
				take_gap_pct = 9;
			end else begin
				send_gap_pct = 0;
				take_gap_pct = 0;
			end

			case ($urandom_range(0, 9))
				0: ws = '0;
				1: ws = WSIZE_BITS'(1);
				2: ws = WSIZE_BITS'(MAX_WINDOW);
				3: ws = WSIZE_BITS'($urandom_range(MAX_WINDOW + 1, 127));
				4: ws = '1;
				5, 6: ws = WSIZE_BITS'($urandom_range(2, 8));
				default: ws = WSIZE_BITS'($urandom_range(1, MAX_WINDOW));
			endcase
			if (first_phase)
				ws = WSIZE_BITS'(MAX_WINDOW);
			set_window(ws);
			eff = (ws == 0) ? 1 : (ws > MAX_WINDOW) ? MAX_WINDOW : ws;

			// a resize may keep its contents only once every ring entry holds a sample
			if (!first_phase && board.ring_full() && $urandom_range(0, 1))
				n_kept++;
			else
				push_word(FUNC_CLEAR, $urandom());
			first_phase = 1'b0;

			run_len = 2 * eff + $urandom_range(1, 40);
			repeat (run_len) begin
				if (!hold_done && n_words > 300) begin
					// long stall on the result side while words keep coming
					hold_request = 1'b1;
					hold_done = 1'b1;
				end
				if ($urandom_range(0, 49) == 0)
					push_word(FUNC_CLEAR, $urandom());
				else
					push_word(FUNC_ADD, pick_sample());
			end
		end

		settle();
		$display("covered %0d window settings (zero, one, full and oversize among them), %0d kept",
			n_settings, n_kept);
		$display("contents across a resize; %0d words sent, %0d clears, %0d results checked",
			n_words, n_clears, board.checked);
		if (board.failures == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
